// ===== src/wrs_pkg.sv =====
// wrs_pkg: shared constants, types and helpers for the water ripple stencil.
// Used by wrs_banks and water_ripple_stencil; depends on nothing.
package wrs_pkg;

  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 128;
  localparam int FRAC_BITS  = 8;

  localparam int CELL_W     = 8 + FRAC_BITS;
  localparam int CELL_COUNT = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int XW         = $clog2(MAX_WIDTH);
  localparam int YW         = $clog2(MAX_HEIGHT);
  localparam int WDIM_W     = $clog2(MAX_WIDTH + 1);
  localparam int HDIM_W     = $clog2(MAX_HEIGHT + 1);

  localparam int POS_W      = 12;
  localparam int DIFF_W     = POS_W + 1;
  localparam int GAIN_W     = 16;
  localparam int DIM_CFG_W  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int CMD_W      = 2;
  localparam int INT_W      = 8;

  localparam logic [CELL_W-1:0] ONE_FX = CELL_W'(1) << FRAC_BITS;
  localparam logic [CELL_W-1:0] TOP_FX = CELL_W'(255) << FRAC_BITS;

  // reset-time grid size and the cell that holds the initial drop
  localparam int RST_W = (128 > MAX_WIDTH) ? MAX_WIDTH : 128;
  localparam int RST_H = (128 > MAX_HEIGHT) ? MAX_HEIGHT : 128;
  localparam logic [ADDR_W-1:0] CENTRE_ADDR =
    ADDR_W'((RST_H / 2) * MAX_WIDTH + (RST_W / 2));

  localparam logic [CMD_W-1:0] CMD_DROP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STEP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING     = 3'd4;

  typedef logic [CELL_W-1:0] cell_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // one read and one write port of a height field
  typedef struct packed {
    addr_t rd_addr;
    logic  wr_en;
    addr_t wr_addr;
    cell_t wr_data;
  } mem_req_t;

  function automatic addr_t cell_addr(input logic [XW-1:0] x, input logic [YW-1:0] y);
    return ADDR_W'(ADDR_W'(y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x));
  endfunction

endpackage

// ===== src/wrs_banks.sv =====
// wrs_banks: the two height fields as synchronous memories, routed by bank select.
// Each field has one write and one registered read port. Depends on wrs_pkg.
module wrs_banks (
  input  logic              clk_i,
  input  logic              bank_i,
  input  wrs_pkg::mem_req_t cur_req_i,
  input  wrs_pkg::mem_req_t prev_req_i,
  output wrs_pkg::cell_t    cur_rdata_o,
  output wrs_pkg::cell_t    prev_rdata_o
);
  import wrs_pkg::*;

  cell_t    field_a [CELL_COUNT];
  cell_t    field_b [CELL_COUNT];
  mem_req_t a_req;
  mem_req_t b_req;
  cell_t    a_rdata_q;
  cell_t    b_rdata_q;
  logic     bank_rd_q;

  assign a_req = bank_i ? prev_req_i : cur_req_i;
  assign b_req = bank_i ? cur_req_i : prev_req_i;

  always_ff @(posedge clk_i) begin
    if (a_req.wr_en) begin
      field_a[a_req.wr_addr] <= a_req.wr_data;
    end
    a_rdata_q <= field_a[a_req.rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (b_req.wr_en) begin
      field_b[b_req.wr_addr] <= b_req.wr_data;
    end
    b_rdata_q <= field_b[b_req.rd_addr];
  end

  // remember which field answered each read
  always_ff @(posedge clk_i) begin
    bank_rd_q <= bank_i;
  end

  assign cur_rdata_o  = bank_rd_q ? b_rdata_q : a_rdata_q;
  assign prev_rdata_o = bank_rd_q ? a_rdata_q : b_rdata_q;

endmodule

// ===== src/water_ripple_stencil.sv =====
// water_ripple_stencil: top level, command sequencer, stencil datapath and registers.
// Instantiates wrs_banks; depends on wrs_pkg.
//
// Two Q8.8 height fields live in single-port-read memories; one transaction of
// any command (drop, step, read or an unused code) gives one result transaction.
// After reset a clearing pass writes all MAX_WIDTH*MAX_HEIGHT cells of both fields
// while in_ready_o stays low; config writes are taken during it. A drop writes in
// S_DROP; a read addresses in S_READ and captures in S_RWAIT. A step walks the
// interior row by row through the current field's single read port: S_ROW0 and
// S_ROW1 load each row's left edge and centre, then S_PH0 to S_PH3 read the right,
// up and down neighbours and shift the window; S_DRAIN empties the damping pipeline.
// The result register lets the next command be accepted while a result waits.
module water_ripple_stencil (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [wrs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [wrs_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [wrs_pkg::CMD_W-1:0]      command_i,
  input  logic [wrs_pkg::POS_W-1:0]      pos_x_i,
  input  logic [wrs_pkg::POS_W-1:0]      pos_y_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [wrs_pkg::INT_W-1:0]      intensity_o,
  output logic                           active_o,
  output logic                           drop_taken_o
);
  import wrs_pkg::*;

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] S_CLEAR  = 4'd0;
  localparam logic [ST_W-1:0] S_IDLE   = 4'd1;
  localparam logic [ST_W-1:0] S_DROP   = 4'd2;
  localparam logic [ST_W-1:0] S_READ   = 4'd3;
  localparam logic [ST_W-1:0] S_RWAIT  = 4'd4;
  localparam logic [ST_W-1:0] S_ROW0   = 4'd5;
  localparam logic [ST_W-1:0] S_ROW1   = 4'd6;
  localparam logic [ST_W-1:0] S_PH0    = 4'd7;
  localparam logic [ST_W-1:0] S_PH1    = 4'd8;
  localparam logic [ST_W-1:0] S_PH2    = 4'd9;
  localparam logic [ST_W-1:0] S_PH3    = 4'd10;
  localparam logic [ST_W-1:0] S_DRAIN  = 4'd11;
  localparam logic [ST_W-1:0] S_FINISH = 4'd12;

  localparam int SUM_W  = CELL_W + 2;
  localparam int HALF_W = CELL_W + 1;
  localparam int PROD_W = HALF_W + GAIN_W;

  // configuration
  logic [DIM_CFG_W-1:0] grid_width_q, grid_height_q;
  logic [POS_W-1:0]     offset_x_q, offset_y_q;
  logic [GAIN_W-1:0]    damping_q;

  // control
  logic [ST_W-1:0]   state_q, state_d;
  logic [ADDR_W-1:0] clr_cnt_q;
  logic              bank_q;
  logic              active_q;
  logic              row_first_q;
  logic [XW-1:0]     x_q;
  logic [YW-1:0]     y_q;
  logic              s1_v_q, s2_v_q;
  logic              out_valid_q;

  // payload
  logic [POS_W-1:0]  px_q, py_q;
  cell_t             left_q, center_q, right_q, up_q, prev_q;
  logic [HALF_W-1:0] dpos_q;
  addr_t             s1_addr_q, s2_addr_q;
  logic [PROD_W-1:0] prod_q;
  logic [INT_W-1:0]  res_int_q, intensity_q;
  logic              res_act_q, res_taken_q, active_out_q, taken_out_q;

  logic [WDIM_W-1:0] eff_w;
  logic [HDIM_W-1:0] eff_h;
  logic              tiny;
  logic              x_last, y_last;
  logic [DIFF_W-1:0] diff_x, diff_y;
  logic              drop_in, read_in;
  logic              in_fire, out_load;
  addr_t             here_addr;
  mem_req_t          cur_req, prev_req;
  cell_t             cur_rdata, prev_rdata;
  logic [SUM_W-1:0]  nb_sum;
  logic [HALF_W-1:0] half;
  logic [SUM_W-1:0]  dval;
  logic [HALF_W-1:0] scaled;
  cell_t             new_cell;

  always_comb begin
    if (int'(grid_width_q) > MAX_WIDTH) begin
      eff_w = WDIM_W'(MAX_WIDTH);
    end else begin
      eff_w = WDIM_W'(grid_width_q);
    end
    if (int'(grid_height_q) > MAX_HEIGHT) begin
      eff_h = HDIM_W'(MAX_HEIGHT);
    end else begin
      eff_h = HDIM_W'(grid_height_q);
    end
  end

  assign tiny   = (eff_w < WDIM_W'(3)) || (eff_h < HDIM_W'(3));
  assign x_last = (WDIM_W'(x_q) + WDIM_W'(2)) >= eff_w;
  assign y_last = (HDIM_W'(y_q) + HDIM_W'(2)) >= eff_h;

  // a negative difference wraps high, so one unsigned compare covers both bounds
  assign diff_x  = {1'b0, px_q} - {1'b0, offset_x_q};
  assign diff_y  = {1'b0, py_q} - {1'b0, offset_y_q};
  assign drop_in = (diff_x != '0) && (diff_x < DIFF_W'(eff_w)) &&
                   (diff_y != '0) && (diff_y < DIFF_W'(eff_h));
  assign read_in = (px_q < POS_W'(eff_w)) && (py_q < POS_W'(eff_h));

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_FINISH) && (!out_valid_q || out_ready_i);

  assign here_addr = cell_addr(x_q, y_q);

  // memory requests
  always_comb begin
    cur_req          = '0;
    prev_req         = '0;
    prev_req.rd_addr = here_addr;
    case (state_q)
      S_READ: cur_req.rd_addr = cell_addr(px_q[XW-1:0], py_q[YW-1:0]);
      S_ROW0: cur_req.rd_addr = cell_addr(XW'(x_q - 1'b1), y_q);
      S_ROW1: cur_req.rd_addr = here_addr;
      S_PH0:  cur_req.rd_addr = cell_addr(XW'(x_q + 1'b1), y_q);
      S_PH1:  cur_req.rd_addr = cell_addr(x_q, YW'(y_q - 1'b1));
      S_PH2:  cur_req.rd_addr = cell_addr(x_q, YW'(y_q + 1'b1));
      default: cur_req.rd_addr = here_addr;
    endcase
    if (state_q == S_CLEAR) begin
      cur_req.wr_en    = 1'b1;
      cur_req.wr_addr  = clr_cnt_q;
      cur_req.wr_data  = '0;
      prev_req.wr_en   = 1'b1;
      prev_req.wr_addr = clr_cnt_q;
      prev_req.wr_data = (clr_cnt_q == CENTRE_ADDR) ? TOP_FX : '0;
    end else begin
      cur_req.wr_en    = (state_q == S_DROP) && drop_in;
      cur_req.wr_addr  = cell_addr(diff_x[XW-1:0], diff_y[YW-1:0]);
      cur_req.wr_data  = TOP_FX;
      prev_req.wr_en   = s2_v_q;
      prev_req.wr_addr = s2_addr_q;
      prev_req.wr_data = new_cell;
    end
  end

  wrs_banks u_banks (
    .clk_i        (clk_i),
    .bank_i       (bank_q),
    .cur_req_i    (cur_req),
    .prev_req_i   (prev_req),
    .cur_rdata_o  (cur_rdata),
    .prev_rdata_o (prev_rdata)
  );

  // stencil arithmetic; the down neighbour arrives straight from memory in S_PH3
  assign nb_sum = SUM_W'(left_q) + SUM_W'(right_q) + SUM_W'(up_q) + SUM_W'(cur_rdata);
  assign half   = nb_sum[SUM_W-1:1];
  assign dval   = {1'b0, half} - SUM_W'(prev_q);
  assign scaled = prod_q[PROD_W-1:GAIN_W];

  always_comb begin
    if (scaled < HALF_W'(ONE_FX)) begin
      new_cell = '0;
    end else if (scaled > HALF_W'(TOP_FX)) begin
      new_cell = TOP_FX;
    end else begin
      new_cell = scaled[CELL_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_cnt_q == ADDR_W'(CELL_COUNT - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          case (command_i)
            CMD_DROP: state_d = S_DROP;
            CMD_READ: state_d = S_READ;
            CMD_STEP: state_d = tiny ? S_DRAIN : S_ROW0;
            default:  state_d = S_FINISH;
          endcase
        end
      end
      S_DROP:  state_d = S_FINISH;
      S_READ:  state_d = S_RWAIT;
      S_RWAIT: state_d = S_FINISH;
      S_ROW0:  state_d = S_ROW1;
      S_ROW1:  state_d = S_PH0;
      S_PH0:   state_d = S_PH1;
      S_PH1:   state_d = S_PH2;
      S_PH2:   state_d = S_PH3;
      S_PH3: begin
        if (!x_last) begin
          state_d = S_PH0;
        end else if (!y_last) begin
          state_d = S_ROW0;
        end else begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!s1_v_q && !s2_v_q) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= DIM_CFG_W'(128);
      grid_height_q <= DIM_CFG_W'(128);
      offset_x_q    <= '0;
      offset_y_q    <= '0;
      damping_q     <= GAIN_W'(65470);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GRID_WIDTH:  grid_width_q  <= cfg_wdata_i[DIM_CFG_W-1:0];
        CFG_GRID_HEIGHT: grid_height_q <= cfg_wdata_i[DIM_CFG_W-1:0];
        CFG_OFFSET_X:    offset_x_q    <= cfg_wdata_i[POS_W-1:0];
        CFG_OFFSET_Y:    offset_y_q    <= cfg_wdata_i[POS_W-1:0];
        CFG_DAMPING:     damping_q     <= cfg_wdata_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      bank_q      <= 1'b0;
      active_q    <= 1'b0;
      row_first_q <= 1'b0;
      x_q         <= '0;
      y_q         <= '0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      s1_v_q  <= (state_q == S_PH3);
      s2_v_q  <= s1_v_q;
      if (state_q == S_CLEAR) begin
        clr_cnt_q <= ADDR_W'(clr_cnt_q + 1'b1);
      end
      if (in_fire) begin
        active_q    <= 1'b0;
        row_first_q <= 1'b1;
        x_q         <= XW'(1);
        y_q         <= YW'(1);
      end
      if (state_q == S_PH3) begin
        row_first_q <= 1'b0;
        if (center_q != '0) begin
          active_q <= 1'b1;
        end
        if (!x_last) begin
          x_q <= XW'(x_q + 1'b1);
        end else begin
          x_q         <= XW'(1);
          y_q         <= YW'(y_q + 1'b1);
          row_first_q <= 1'b1;
        end
      end
      if ((state_q == S_DRAIN) && (state_d == S_FINISH)) begin
        bank_q <= ~bank_q;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath and result registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      px_q        <= pos_x_i;
      py_q        <= pos_y_i;
      res_int_q   <= '0;
      res_act_q   <= 1'b0;
      res_taken_q <= 1'b0;
    end
    case (state_q)
      S_DROP:  res_taken_q <= drop_in;
      S_RWAIT: res_int_q   <= read_in ? cur_rdata[FRAC_BITS +: INT_W] : '0;
      S_ROW1:  left_q      <= cur_rdata;
      S_PH0: begin
        if (row_first_q) begin
          center_q <= cur_rdata;
        end
      end
      S_PH1: begin
        right_q <= cur_rdata;
        prev_q  <= prev_rdata;
      end
      S_PH2: up_q <= cur_rdata;
      S_PH3: begin
        // positive differences only; the rest become zero
        dpos_q    <= dval[SUM_W-1] ? '0 : dval[HALF_W-1:0];
        s1_addr_q <= here_addr;
        left_q    <= center_q;
        center_q  <= right_q;
      end
      S_DRAIN: begin
        if (!s1_v_q && !s2_v_q) begin
          res_act_q <= active_q;
        end
      end
      default: ;
    endcase
    prod_q    <= dpos_q * damping_q;
    s2_addr_q <= s1_addr_q;
    if (out_load) begin
      intensity_q  <= res_int_q;
      active_out_q <= res_act_q;
      taken_out_q  <= res_taken_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign intensity_o  = intensity_q;
  assign active_o     = active_out_q;
  assign drop_taken_o = taken_out_q;

  // fields swap only at the end of a step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_DRAIN) |=> (bank_q == $past(bank_q)))
    else $error("bank select changed outside the step drain");

  // damped values are written back only while a step runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q |-> (state_q == S_PH0 || state_q == S_PH1 || state_q == S_PH2 ||
                state_q == S_PH3 || state_q == S_ROW0 || state_q == S_ROW1 ||
                state_q == S_DRAIN))
    else $error("previous field written outside a step");

  // an accepted transaction always leaves idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q != S_IDLE))
    else $error("accepted transaction did not start");

endmodule

// ===== bench/water_ripple_stencil_tb.sv =====
// water_ripple_stencil_tb: self-checking bench for the water ripple stencil.
// Drives commands through a queue-fed driver and scores results against a
// behavioral copy of both height fields; depends on wrs_pkg and the block.
module water_ripple_stencil_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wrs_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
  } ripple_cmd_t;

  typedef struct packed {
    logic [INT_W-1:0] intensity;
    logic             active;
    logic             drop_taken;
  } ripple_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [CMD_W-1:0]      command_i = '0;
  logic [POS_W-1:0]      pos_x_i = '0;
  logic [POS_W-1:0]      pos_y_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [INT_W-1:0]      intensity_o;
  logic                  active_o;
  logic                  drop_taken_o;

  water_ripple_stencil uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .intensity_o  (intensity_o),
    .active_o     (active_o),
    .drop_taken_o (drop_taken_o)
  );

  always #10 clk_i = ~clk_i;

  // shadow of the block: both fields, bank pointer and registers
  logic [CELL_W-1:0] height_map [2][CELL_COUNT];
  bit                live_bank;
  int unsigned       cols_cfg, rows_cfg, shift_x, shift_y, damp_gain;

  ripple_cmd_t    pending_cmds [$];
  ripple_result_t ripple_results_due [$];
  ripple_cmd_t    on_wire;

  int idle_mode;
  int mismatch_count;
  int results_checked;
  int n_drop, n_step, n_read, n_other, drops_taken, steps_active;

  function automatic int unsigned cols_in_use();
    return (cols_cfg > MAX_WIDTH) ? MAX_WIDTH : cols_cfg;
  endfunction

  function automatic int unsigned rows_in_use();
    return (rows_cfg > MAX_HEIGHT) ? MAX_HEIGHT : rows_cfg;
  endfunction

  // one frame of the stencil; returns whether any interior current cell was set
  function automatic bit ripple_advance();
    int unsigned w, h, x, y, idx;
    longint nsum, diff, scaled;
    logic [CELL_W-1:0] nv;
    bit any;
    w = cols_in_use();
    h = rows_in_use();
    any = 1'b0;
    for (x = 1; x + 1 < w; x++) begin
      for (y = 1; y + 1 < h; y++) begin
        idx = x + y * MAX_WIDTH;
        nsum = longint'(height_map[live_bank][idx - 1]) +
               longint'(height_map[live_bank][idx + 1]) +
               longint'(height_map[live_bank][idx - MAX_WIDTH]) +
               longint'(height_map[live_bank][idx + MAX_WIDTH]);
        diff = (nsum >>> 1) - longint'(height_map[!live_bank][idx]);
        nv = '0;
        if (diff > 0) begin
          scaled = (diff * longint'(damp_gain)) >>> 16;
          if (scaled < longint'(ONE_FX)) nv = '0;
          else if (scaled > longint'(TOP_FX)) nv = TOP_FX;
          else nv = scaled[CELL_W-1:0];
        end
        height_map[!live_bank][idx] = nv;
        if (height_map[live_bank][idx] != '0) any = 1'b1;
      end
    end
    live_bank = !live_bank;
    return any;
  endfunction

  function automatic void predict_ripple(input ripple_cmd_t it);
    ripple_result_t r;
    int dx, dy;
    int unsigned w, h;
    r = '0;
    w = cols_in_use();
    h = rows_in_use();
    case (it.command)
      CMD_DROP: begin
        n_drop++;
        dx = int'(it.pos_x) - int'(shift_x);
        dy = int'(it.pos_y) - int'(shift_y);
        if (dx > 0 && dy > 0 && dx < int'(w) && dy < int'(h)) begin
          height_map[live_bank][dx + dy * MAX_WIDTH] = TOP_FX;
          r.drop_taken = 1'b1;
          drops_taken++;
        end
      end
      CMD_STEP: begin
        n_step++;
        r.active = ripple_advance();
        if (r.active) steps_active++;
      end
      CMD_READ: begin
        n_read++;
        if (it.pos_x < w && it.pos_y < h)
          r.intensity = INT_W'(height_map[live_bank][it.pos_x + it.pos_y * MAX_WIDTH]
                               >> FRAC_BITS);
      end
      default: n_other++;
    endcase
    ripple_results_due.insert(ripple_results_due.size(), r);
  endfunction

  function automatic bit stall_now(input bit sender);
    int unsigned pct;
    if (idle_mode == 0) pct = sender ? 24 : 67;
    else if (idle_mode == 1) pct = sender ? 67 : 24;
    else pct = 0;
    return $urandom_range(0, 99) < pct;
  endfunction

  // driver: offers queued commands, predicts each accepted transaction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) predict_ripple(on_wire);
      if (!in_valid_i || in_ready_o) begin
        if (pending_cmds.size() != 0 && !stall_now(1'b1)) begin
          on_wire = pending_cmds.pop_front();
          in_valid_i <= 1'b1;
          command_i  <= on_wire.command;
          pos_x_i    <= on_wire.pos_x;
          pos_y_i    <= on_wire.pos_y;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: scores results, throttles out_ready_i
  int  hold_left;
  bit  long_hold_done;
  ripple_result_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_checked++;
        if (ripple_results_due.size() == 0) begin
          $display("%0t: unexpected result intensity %0d active %0b drop_taken %0b",
                   $time, intensity_o, active_o, drop_taken_o);
          mismatch_count++;
        end else begin
          want = ripple_results_due.pop_front();
          if (want.intensity !== intensity_o) begin
            $display("%0t: intensity expected %0d got %0d", $time,
                     want.intensity, intensity_o);
            mismatch_count++;
          end
          if (want.active !== active_o) begin
            $display("%0t: active expected %0b got %0b", $time, want.active, active_o);
            mismatch_count++;
          end
          if (want.drop_taken !== drop_taken_o) begin
            $display("%0t: drop_taken expected %0b got %0b", $time,
                     want.drop_taken, drop_taken_o);
            mismatch_count++;
          end
        end
      end
      // one long back-pressure stretch so the block fills and stalls its input
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!long_hold_done && results_checked == 45) begin
        long_hold_done = 1'b1;
        hold_left = 300;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !stall_now(1'b0);
      end
    end
  end

  task automatic queue_item(input logic [CMD_W-1:0] cmd, input int unsigned x,
                            input int unsigned y);
    ripple_cmd_t it;
    it.command = cmd;
    it.pos_x = POS_W'(x);
    it.pos_y = POS_W'(y);
    pending_cmds.insert(pending_cmds.size(), it);
  endtask

  function automatic ripple_cmd_t random_item();
    ripple_cmd_t it;
    int unsigned roll, w, h;
    w = cols_in_use();
    h = rows_in_use();
    roll = $urandom_range(0, 99);
    it.pos_x = POS_W'($urandom);
    it.pos_y = POS_W'($urandom);
    if (roll < 35) begin
      it.command = CMD_DROP;
      it.pos_x = POS_W'(shift_x + $urandom_range(0, w));
      it.pos_y = POS_W'(shift_y + $urandom_range(0, h));
    end else if (roll < 60) begin
      it.command = CMD_READ;
      it.pos_x = POS_W'($urandom_range(0, w));
      it.pos_y = POS_W'($urandom_range(0, h));
    end else if (roll < 85) begin
      it.command = CMD_STEP;
    end else if (roll < 90) begin
      it.command = CMD_UNUSED;
    end else begin
      it.command = $urandom_range(0, 1) ? CMD_DROP : CMD_READ;
    end
    return it;
  endfunction

  // wait until every queued transaction is accepted and every result is in
  task automatic drain_results();
    do @(negedge clk_i);
    while (pending_cmds.size() != 0 || in_valid_i || ripple_results_due.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_GRID_WIDTH:  cols_cfg  = data[7:0];
      CFG_GRID_HEIGHT: rows_cfg  = data[7:0];
      CFG_OFFSET_X:    shift_x   = data[11:0];
      CFG_OFFSET_Y:    shift_y   = data[11:0];
      CFG_DAMPING:     damp_gain = data;
      default: ;
    endcase
  endtask

  // unused upper data bits are filled with noise
  task automatic apply_config(input int unsigned cols, input int unsigned rows,
                              input int unsigned sx, input int unsigned sy,
                              input int unsigned gain);
    write_reg(CFG_GRID_WIDTH,  16'(cols) | 16'($urandom_range(0, 255) << 8));
    write_reg(CFG_GRID_HEIGHT, 16'(rows) | 16'($urandom_range(0, 255) << 8));
    write_reg(CFG_OFFSET_X,    16'(sx) | 16'($urandom_range(0, 15) << 12));
    write_reg(CFG_OFFSET_Y,    16'(sy) | 16'($urandom_range(0, 15) << 12));
    write_reg(CFG_DAMPING,     16'(gain));
  endtask

  initial begin : main_seq
    int unsigned cols, rows, sx, sy, gain;
    int rp, k;
    for (k = 0; k < CELL_COUNT; k++) begin
      height_map[0][k] = '0;
      height_map[1][k] = '0;
    end
    height_map[1][CENTRE_ADDR] = TOP_FX;
    live_bank = 1'b0;
    cols_cfg = 128;
    rows_cfg = 128;
    shift_x = 0;
    shift_y = 0;
    damp_gain = 65470;
    idle_mode = 0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset geometry: bounds of reads and drops, unknown command
    queue_item(CMD_READ, 64, 64);
    queue_item(CMD_READ, 127, 127);
    queue_item(CMD_READ, 128, 5);
    queue_item(CMD_READ, 4095, 4095);
    queue_item(CMD_DROP, 0, 5);
    queue_item(CMD_DROP, 5, 0);
    queue_item(CMD_DROP, 1, 1);
    queue_item(CMD_DROP, 127, 127);
    queue_item(CMD_DROP, 128, 3);
    queue_item(CMD_DROP, 3, 128);
    queue_item(CMD_DROP, 64, 63);
    queue_item(CMD_UNUSED, 4095, 4095);
    queue_item(CMD_READ, 1, 1);
    drain_results();

    // zero width, oversized height: step only swaps the fields
    apply_config(0, 200, 4095, 0, 0);
    queue_item(CMD_STEP, 0, 0);
    queue_item(CMD_DROP, 4095, 1);
    queue_item(CMD_READ, 0, 0);
    drain_results();

    // back to full size: the reset drop is now current, then one full frame
    apply_config(128, 128, 0, 0, 65470);
    queue_item(CMD_READ, 64, 64);
    queue_item(CMD_STEP, 4095, 4095);
    queue_item(CMD_READ, 64, 64);
    drain_results();

    // smallest grid with one interior cell, full gain clamps at 255
    apply_config(3, 3, 10, 10, 65535);
    queue_item(CMD_DROP, 11, 11);
    queue_item(CMD_DROP, 13, 11);
    queue_item(CMD_STEP, 0, 0);
    queue_item(CMD_READ, 1, 1);
    queue_item(CMD_STEP, 0, 0);
    queue_item(CMD_READ, 1, 1);
    drain_results();

    for (rp = 0; rp < 8; rp++) begin
      idle_mode = rp * 3 / 8;
      cols = $urandom_range(3, 16);
      rows = $urandom_range(3, 16);
      sx = $urandom_range(0, 4095);
      sy = $urandom_range(0, 4095);
      gain = $urandom_range(0, 65535);
      case (rp)
        0: begin
          cols = $urandom_range(4, 12);
          rows = $urandom_range(4, 12);
          sx = 0;
          sy = 0;
          gain = 65535;
        end
        1: begin
          cols = 255;
          rows = 3;
        end
        2: gain = 0;
        3: begin
          cols = 3;
          rows = 130;
          gain = 65470;
        end
        // weak damping pushes most cells under one
        4: gain = $urandom_range(256, 1024);
        5: begin
          cols = $urandom_range(3, 20);
          rows = $urandom_range(3, 20);
        end
        6: begin
          cols = $urandom_range(0, 2);
          rows = $urandom_range(0, 20);
        end
        default: gain = 65470;
      endcase
      apply_config(cols, rows, sx, sy, gain);
      repeat (12) pending_cmds.insert(pending_cmds.size(), random_item());
      drain_results();
    end

    // catch any stray result after the last one due
    repeat (64) @(posedge clk_i);
    $display("covered %0d drops (%0d taken), %0d steps (%0d active), %0d reads, %0d unknown",
             n_drop, drops_taken, n_step, steps_active, n_read, n_other);
    $display("%0d results checked over 12 register settings, %0d mismatches",
             results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
